// File: rtl/core/pica_pkg.sv
// Package for the PI regulator with back-calculation anti-windup.
// Holds the sequencer states, register and opcode codes, and saturation helpers.
// Depends on nothing.
`timescale 1ns / 1ps

package pica_pkg;

	// Field and port widths
	localparam int VAL_W     = 32;
	localparam int ERR_W     = 16;
	localparam int DT_W      = 16;
	localparam int CFG_IDX_W = 3;
	localparam int S_DATA_W  = 96;
	localparam int S_USER_W  = 2;
	localparam int M_DATA_W  = 64;
	localparam int M_USER_W  = 2;

	// Shared multiplier: 33-bit signed by 17-bit signed
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LOWER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_UPPER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER = 3'd5;

	// Opcodes
	localparam logic OP_UPDATE  = 1'b0;
	localparam logic OP_PRELOAD = 1'b1;

	// Full-scale values
	localparam logic signed [VAL_W-1:0] FS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] FS_MIN = 32'sh8000_0000;
	localparam logic signed [MUL_P_W-1:0] SAT_HI = 50'sd2147483647;
	localparam logic signed [MUL_P_W-1:0] SAT_LO = -50'sd2147483648;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_KE,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_INC,
		ST_INTEG,
		ST_OUTPUT,
		ST_BACK,
		ST_DONE
	} state_t;

	// Saturate a wide product or sum to 32 bits
	function automatic logic signed [VAL_W-1:0] sat_wide(input logic signed [MUL_P_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > SAT_HI) begin
			r = FS_MAX;
		end else if (v < SAT_LO) begin
			r = FS_MIN;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	// Clamp to a limit pair, taking the pair in either order
	function automatic logic signed [VAL_W-1:0] clamp_pair(input logic signed [VAL_W+1:0] v,
			input logic signed [VAL_W-1:0] a, input logic signed [VAL_W-1:0] b);
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		logic signed [VAL_W-1:0] r;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/pi_controller_antiwindup_top.sv
// PI regulator with back-calculation anti-windup, sequenced around one multiplier.
// Depends on pica_pkg (states, register codes, saturation functions).
//
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tdata: error_in, step_time, preload_integ,
//                                        preload_out; tuser: opcode, sample_bad
// m_*      out        m_tvalid/m_tready  tdata: drive_out, integ_now; tuser: held, saturated
// cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// An update step runs from accept to result valid through four passes of the
// shared 33x17 multiplier (kp*e, ki*e, then the high and low halves of ki*e times dt),
// then rounding, integral clamp, output clamp and back-calculation, in that order.
// A preload, zero step or bad sample shows its result in the cycle after accept.
// One item at a time: s_tready is high only when no item is in work or waiting.
// Reset clears gains to 0, limits to full scale, integral and last output to 0.
`timescale 1ns / 1ps

module pi_controller_antiwindup_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [15:0] error_in, [31:16] step_time, [63:32] preload_integ, [95:64] preload_out
	input  logic [pica_pkg::S_DATA_W-1:0]     s_tdata,
	// [0] opcode, [1] sample_bad
	input  logic [pica_pkg::S_USER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [31:0] drive_out, [63:32] integ_now
	output logic [pica_pkg::M_DATA_W-1:0]     m_tdata,
	// [0] held, [1] saturated
	output logic [pica_pkg::M_USER_W-1:0]     m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pica_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pica_pkg::VAL_W-1:0]        cfg_data
);

	import pica_pkg::*;

	state_t state_q, state_d;

	// Configuration and controller state
	logic signed [VAL_W-1:0] prop_gain_q, integ_gain_q;
	logic signed [VAL_W-1:0] out_lower_q, out_upper_q, integ_lower_q, integ_upper_q;
	logic signed [VAL_W-1:0] integ_acc_q, last_drive_q;
	logic                    held_q, sat_q;

	// Working registers
	logic signed [ERR_W-1:0]   err_q;
	logic [DT_W-1:0]           dt_q;
	logic signed [MUL_P_W-1:0] mul_q;
	logic signed [VAL_W-1:0]   p_q;
	logic [15:0]               ke_lo_q;
	logic signed [47:0]        hi_q;
	logic signed [VAL_W-1:0]   inc_q, it_q;
	logic signed [VAL_W+1:0]   back_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;

	logic                    s_acc, cfg_acc, in_op, in_bad;
	logic signed [ERR_W-1:0] in_err;
	logic [DT_W-1:0]         in_dt;
	logic signed [VAL_W-1:0] in_pi, in_po;
	logic signed [VAL_W-1:0] omin, omax;
	logic [16:0]             rnd;
	logic signed [MUL_P_W-1:0] inc_sum;
	logic signed [VAL_W+1:0] o_sum;

	assign in_op   = s_tuser[0];
	assign in_bad  = s_tuser[1];
	assign in_err  = s_tdata[15:0];
	assign in_dt   = s_tdata[31:16];
	assign in_pi   = s_tdata[63:32];
	assign in_po   = s_tdata[95:64];
	assign s_acc   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_acc = cfg_valid && cfg_ready;

	assign m_tdata = {integ_acc_q, last_drive_q};
	assign m_tuser = {sat_q, held_q};

	// Output limits in force, swapped when written in reverse
	assign omin = (out_lower_q < out_upper_q) ? out_lower_q : out_upper_q;
	assign omax = (out_lower_q < out_upper_q) ? out_upper_q : out_lower_q;

	// Select operands for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_P: begin
				mul_a = MUL_A_W'(prop_gain_q);
				mul_b = MUL_B_W'(err_q);
			end
			ST_MUL_KE: begin
				mul_a = MUL_A_W'(integ_gain_q);
				mul_b = MUL_B_W'(err_q);
			end
			ST_MUL_HI: begin
				mul_a = MUL_A_W'($signed(mul_q[47:16]));
				mul_b = $signed({1'b0, dt_q});
			end
			ST_MUL_LO: begin
				mul_a = $signed({17'd0, ke_lo_q});
				mul_b = $signed({1'b0, dt_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Round the low partial product and add it to the high one
	assign rnd     = 17'((mul_q[31:0] + 33'd32768) >> 16);
	assign inc_sum = MUL_P_W'(hi_q) + $signed({33'd0, rnd});
	assign o_sum   = (VAL_W+2)'(p_q) + (VAL_W+2)'(it_q);

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_op == OP_PRELOAD || in_dt == '0 || in_bad) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_MUL_P;
					end
				end
			end
			ST_MUL_P:  state_d = ST_MUL_KE;
			ST_MUL_KE: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_INC;
			ST_INC:    state_d = ST_INTEG;
			ST_INTEG:  state_d = ST_OUTPUT;
			ST_OUTPUT: state_d = ST_BACK;
			ST_BACK:   state_d = ST_DONE;
			ST_DONE: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold configuration and controller state; apply writes, preloads and updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= '0;
			integ_gain_q  <= '0;
			out_lower_q   <= FS_MIN;
			out_upper_q   <= FS_MAX;
			integ_lower_q <= FS_MIN;
			integ_upper_q <= FS_MAX;
			integ_acc_q   <= '0;
			last_drive_q  <= '0;
			held_q        <= 1'b0;
			sat_q         <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
					REG_INTEG_GAIN: integ_gain_q <= cfg_data;
					REG_OUT_LOWER:  out_lower_q  <= cfg_data;
					REG_OUT_UPPER:  out_upper_q  <= cfg_data;
					REG_INTEG_LOWER: begin
						integ_lower_q <= cfg_data;
						integ_acc_q   <= clamp_pair((VAL_W+2)'(integ_acc_q), cfg_data,
								integ_upper_q);
					end
					REG_INTEG_UPPER: begin
						integ_upper_q <= cfg_data;
						integ_acc_q   <= clamp_pair((VAL_W+2)'(integ_acc_q), integ_lower_q,
								cfg_data);
					end
					default: ;
				endcase
			end
			if (s_acc) begin
				held_q <= (in_op == OP_UPDATE) && (in_dt == '0 || in_bad);
				sat_q  <= 1'b0;
				if (in_op == OP_PRELOAD) begin
					integ_acc_q  <= clamp_pair((VAL_W+2)'(in_pi), integ_lower_q, integ_upper_q);
					last_drive_q <= clamp_pair((VAL_W+2)'(in_po), out_lower_q, out_upper_q);
				end
			end
			// Output clamp with back-calculation of the integral
			if (state_q == ST_OUTPUT) begin
				if (o_sum > omax) begin
					last_drive_q <= omax;
					sat_q        <= 1'b1;
				end else if (o_sum < omin) begin
					last_drive_q <= omin;
					sat_q        <= 1'b1;
				end else begin
					last_drive_q <= o_sum[VAL_W-1:0];
				end
			end
			if (state_q == ST_BACK) begin
				integ_acc_q <= clamp_pair(back_q, integ_lower_q, integ_upper_q);
			end
		end
	end

	// Datapath registers of the update sequence
	always_ff @(posedge clk) begin
		if (s_acc) begin
			err_q <= in_err;
			dt_q  <= in_dt;
		end
		unique case (state_q)
			ST_MUL_P: mul_q <= mul_p;
			ST_MUL_KE: begin
				p_q   <= sat_wide(mul_q);
				mul_q <= mul_p;
			end
			ST_MUL_HI: begin
				ke_lo_q <= mul_q[15:0];
				mul_q   <= mul_p;
			end
			ST_MUL_LO: begin
				hi_q  <= mul_q[47:0];
				mul_q <= mul_p;
			end
			ST_INC:   inc_q <= sat_wide(inc_sum);
			ST_INTEG: it_q  <= clamp_pair((VAL_W+2)'(integ_acc_q) + (VAL_W+2)'(inc_q),
					integ_lower_q, integ_upper_q);
			ST_OUTPUT: begin
				if (o_sum > omax) begin
					back_q <= (VAL_W+2)'(omax) - (VAL_W+2)'(p_q);
				end else if (o_sum < omin) begin
					back_q <= (VAL_W+2)'(omin) - (VAL_W+2)'(p_q);
				end else begin
					back_q <= (VAL_W+2)'(it_q);
				end
			end
			default: ;
		endcase
	end

	// Checks on sequencing and on the stored values
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	a_held_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("held and saturated both set");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (last_drive_q == omin || last_drive_q == omax))
		else $error("saturated output not at a limit");

	a_integ_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((integ_acc_q >= integ_lower_q && integ_acc_q <= integ_upper_q) ||
			(integ_acc_q >= integ_upper_q && integ_acc_q <= integ_lower_q)))
		else $error("integral outside its limits");

	a_back_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BACK) |=> m_tvalid)
		else $error("result not presented after back-calculation");

endmodule
